FILE: rtl/otcr_pkg.sv
// Shared types, field positions, codes and constants of the OpenTherm change reporter.
package otcr_pkg;

  // Field positions within the monitored 32-bit frame.
  localparam int VALUE_W  = 16;
  localparam int ID_W     = 8;
  localparam int ID_LSB   = 16;
  localparam int TYPE_W   = 3;
  localparam int TYPE_LSB = 28;

  // The known map and the report carry six bits of id.
  localparam int KNOWN_IDX_W = 6;
  localparam int KNOWN_BITS  = 64;

  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [ID_W-1:0]        data_id_t;
  typedef logic [TYPE_W-1:0]      msg_type_t;
  typedef logic [KNOWN_IDX_W-1:0] short_id_t;
  typedef logic [1:0]             kind_t;

  // Message types that the block reacts to.
  localparam msg_type_t MT_READ_DATA  = 3'd0;
  localparam msg_type_t MT_WRITE_DATA = 3'd1;
  localparam msg_type_t MT_READ_ACK   = 3'd4;

  // Data ids with a handling of their own.
  localparam data_id_t ID_STATUS    = 8'd0;
  localparam data_id_t ID_SLAVE_ASF = 8'd5;

  // Report kinds.
  localparam kind_t KIND_STATUS  = 2'd0;
  localparam kind_t KIND_FLAGS   = 2'd1;
  localparam kind_t KIND_NUMERIC = 2'd2;

  // Masks.
  localparam value_t MASK_STATUS_ALL = 16'h1fff;
  localparam value_t MASK_MASTER     = 16'hff00;
  localparam value_t MASK_SLAVE      = 16'h00ff;
  localparam value_t MASK_ASF_ALL    = 16'h3fff;
  localparam value_t MASK_NUMERIC    = 16'hffff;

  // Which message types carry a numeric id's value.
  typedef struct packed {
    logic on_write;
    logic on_ack;
  } num_class_t;

  // Outcome of one frame against the stored entry.
  typedef struct packed {
    logic   wr_en;
    value_t wr_data;
    logic   set_known;
    logic   report;
    kind_t  kind;
    value_t mask;
  } decision_t;

  function automatic num_class_t numeric_class(input data_id_t id);
    num_class_t cls;
    cls = '0;
    unique case (id) inside
      8'd1, 8'd8, 8'd14, 8'd16, 8'd23, 8'd24, 8'd37: begin
        cls.on_write = 1'b1;
      end
      8'd9, 8'd17, 8'd25, 8'd26, 8'd28, 8'd31, 8'd32, 8'd56, 8'd57: begin
        cls.on_ack = 1'b1;
      end
      8'd27: begin
        cls.on_write = 1'b1;
        cls.on_ack   = 1'b1;
      end
      default: begin
        cls = '0;
      end
    endcase
    return cls;
  endfunction

endpackage

FILE: rtl/otcr_if.sv
// Valid/ready channel interfaces for frames in and change reports out.
interface otcr_in_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          frame_word;

  modport source (output valid, output frame_word, input ready);
  modport sink   (input valid, input frame_word, output ready);
endinterface

interface otcr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  report_id;
  logic [1:0]  report_kind;
  logic [15:0] report_value;
  logic [15:0] report_mask;

  modport source (output valid, output report_id, output report_kind,
                  output report_value, output report_mask, input ready);
  modport sink   (input valid, input report_id, input report_kind,
                  input report_value, input report_mask, output ready);
endinterface

FILE: rtl/otcr_eval.sv
// Decides the store update and the report for one frame against its stored entry.
module otcr_eval (
  input  otcr_pkg::value_t    value,
  input  otcr_pkg::data_id_t  id,
  input  otcr_pkg::msg_type_t mtype,
  input  otcr_pkg::value_t    cur,
  input  logic                known,
  output otcr_pkg::decision_t dec
);
  import otcr_pkg::*;

  value_t     change;
  value_t     mask;
  value_t     stored;
  num_class_t cls;
  logic       take;

  always_comb begin
    change = value ^ cur;
    stored = (value == '0) ? 16'd1 : value;
    cls    = numeric_class(id);
    mask   = '0;
    take   = 1'b0;
    dec    = '0;

    if (id == ID_STATUS) begin
      // Until the status word is known, every flag is reported.
      mask = known ? change : MASK_STATUS_ALL;
      if (mtype == MT_READ_DATA) begin
        mask = mask & MASK_MASTER;
        take = 1'b1;
      end else if (mtype == MT_READ_ACK) begin
        mask          = mask & MASK_SLAVE;
        dec.set_known = 1'b1;
        take          = 1'b1;
      end
      if (take && (mask != '0)) begin
        dec.wr_en   = 1'b1;
        dec.wr_data = cur ^ (change & mask);
        dec.report  = 1'b1;
        dec.kind    = KIND_STATUS;
        dec.mask    = mask;
      end
    end else if (id == ID_SLAVE_ASF) begin
      if (mtype == MT_READ_ACK) begin
        mask = known ? change : MASK_ASF_ALL;
        if (mask != '0) begin
          dec.wr_en     = 1'b1;
          dec.wr_data   = cur ^ (change & mask);
          dec.set_known = 1'b1;
          dec.report    = 1'b1;
          dec.kind      = KIND_FLAGS;
          dec.mask      = mask;
        end
      end
    end else if ((mtype == MT_WRITE_DATA && cls.on_write) ||
                 (mtype == MT_READ_ACK && cls.on_ack)) begin
      // A numeric zero is kept as one, so the first sample always reports.
      if (stored != cur) begin
        dec.wr_en     = 1'b1;
        dec.wr_data   = stored;
        dec.set_known = 1'b1;
        dec.report    = 1'b1;
        dec.kind      = KIND_NUMERIC;
        dec.mask      = MASK_NUMERIC;
      end
    end
  end

endmodule

FILE: rtl/opentherm_change_reporter_top.sv
// Top level of the OpenTherm change reporter: value store, pipeline and report register.
//
// The block watches monitored OpenTherm frames on in_ch and sends a report
// item on out_ch only when a frame changes what is remembered for its id.
// Both channels use valid/ready; an item moves on a rising edge with both high.
// Each frame yields zero or one report item, in frame order.
//
// Pipeline: the accepting edge issues a read of the value store (a synchronous
// single-port-write memory with a registered read port). In the next cycle
// the frame is judged against the stored entry; when the judging stage
// advances, the entry is written back and any report is loaded into the output
// register. A frame can be accepted on every cycle while out_ch does not stall; a
// write-back register forwards the newest entry to a frame whose read was issued
// before that write landed. Sustained rate is one item per cycle without stalls.
//
// Reset (synchronous, rst_n low) clears the known map and a valid bit per
// store entry; an entry whose valid bit is clear reads as zero, so no clearing
// pass is needed and the block accepts frames from the first cycle after reset.
// When out_ch stalls, the report register holds its item and the judging stage
// holds its frame; in_ch is ready while the judging stage is empty or advancing.
module opentherm_change_reporter_top #(
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  otcr_in_if.sink    in_ch,
  otcr_out_if.source out_ch
);
  import otcr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  typedef logic [AW-1:0] addr_t;

  // Value store and its per-entry valid bits.
  value_t                 mem [STORE_DEPTH];
  value_t                 rd_q_r;
  logic [STORE_DEPTH-1:0] valid_r;
  logic [STORE_DEPTH-1:0] valid_nxt;

  // Known map.
  logic [KNOWN_BITS-1:0] known_r;
  logic [KNOWN_BITS-1:0] known_nxt;

  // Judging stage.
  logic      s1_valid_r, s1_valid_nxt;
  value_t    s1_value_r;
  data_id_t  s1_id_r;
  msg_type_t s1_type_r;
  addr_t     s1_addr;

  // Last write-back, used for forwarding.
  logic   lw_valid_r, lw_valid_nxt;
  addr_t  lw_addr_r;
  value_t lw_data_r;

  // Report register.
  logic      out_valid_r, out_valid_nxt;
  short_id_t out_id_r;
  kind_t     out_kind_r;
  value_t    out_value_r;
  value_t    out_mask_r;

  logic      in_accept;
  logic      s1_adv;
  logic      s1_fire;
  addr_t     in_addr;
  value_t    cur;
  decision_t dec;
  logic      wr_en;

  // Addresses come from the low six bits of the id; higher ids are ignored
  // by the judging logic, so their aliasing reads do no harm.
  assign in_addr = AW'(in_ch.frame_word[ID_LSB +: KNOWN_IDX_W]);
  assign s1_addr = AW'(s1_id_r[KNOWN_IDX_W-1:0]);

  assign s1_adv    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept = in_ch.valid && in_ch.ready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign wr_en     = s1_fire && dec.wr_en;

  // Newest value of the entry: forwarded write-back, else memory, else zero.
  always_comb begin
    if (lw_valid_r && (lw_addr_r == s1_addr)) begin
      cur = lw_data_r;
    end else if (valid_r[s1_addr]) begin
      cur = rd_q_r;
    end else begin
      cur = '0;
    end
  end

  otcr_eval u_eval (
    .value (s1_value_r),
    .id    (s1_id_r),
    .mtype (s1_type_r),
    .cur   (cur),
    .known (known_r[s1_id_r[KNOWN_IDX_W-1:0]]),
    .dec   (dec)
  );

  // Memory: read on acceptance, write back from the judging stage.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_q_r <= mem[in_addr];
    end
    if (wr_en) begin
      mem[s1_addr] <= dec.wr_data;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[s1_addr] = 1'b1;
    end
  end

  always_comb begin
    known_nxt = known_r;
    if (s1_fire && dec.set_known) begin
      known_nxt[s1_id_r[KNOWN_IDX_W-1:0]] = 1'b1;
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  assign lw_valid_nxt = lw_valid_r || wr_en;

  always_comb begin
    if (s1_fire && dec.report) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      known_r     <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      known_r     <= known_nxt;
      s1_valid_r  <= s1_valid_nxt;
      lw_valid_r  <= lw_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_value_r <= in_ch.frame_word[VALUE_W-1:0];
      s1_id_r    <= in_ch.frame_word[ID_LSB +: ID_W];
      s1_type_r  <= in_ch.frame_word[TYPE_LSB +: TYPE_W];
    end
    if (wr_en) begin
      lw_addr_r <= s1_addr;
      lw_data_r <= dec.wr_data;
    end
    if (s1_fire && dec.report) begin
      out_id_r    <= s1_id_r[KNOWN_IDX_W-1:0];
      out_kind_r  <= dec.kind;
      out_value_r <= s1_value_r;
      out_mask_r  <= dec.mask;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.report_id    = out_id_r;
  assign out_ch.report_kind  = out_kind_r;
  assign out_ch.report_value = out_value_r;
  assign out_ch.report_mask  = out_mask_r;

  // Each report kind belongs to its own ids.
  a_kind_matches_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_kind_r == KIND_STATUS && out_id_r == 6'd0) ||
      (out_kind_r == KIND_FLAGS && out_id_r == 6'd5) ||
      (out_kind_r == KIND_NUMERIC && out_id_r != 6'd0 && out_id_r != 6'd5))
    else $error("report kind does not match its id");

  // Numeric reports always carry a full mask.
  a_numeric_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_NUMERIC) |-> (out_mask_r == MASK_NUMERIC))
    else $error("numeric report without full mask");

  // A written entry is valid from the next cycle on.
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(s1_addr)])
    else $error("store entry written but not marked valid");

  // Ids never become unknown again outside reset.
  a_known_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((known_r & $past(known_r)) == $past(known_r)))
    else $error("known map lost a bit");

endmodule
